// ===== design/psm_pkg.sv =====
// Package for the packed symmetric matrix multiply-accumulate block.
// Holds the beat types, the cell-chain token, the store write bus and the
// packed-position decode. Depends on nothing.
package psm_pkg;

  localparam int DIM_DEF   = 4;
  localparam int DIM_MAX   = 16;
  localparam int IDX_W     = $clog2(DIM_MAX);
  localparam int POS_W     = 4;
  localparam int VAL_W     = 32;
  localparam int OUT_IDX_W = 2;
  // Triangle rows that a position of POS_W bits can reach.
  localparam int TRI_SCAN  = 6;

  // Values of operation_mode.
  localparam logic MODE_SUM     = 1'b0;
  localparam logic MODE_PRODUCT = 1'b1;

  typedef struct packed {
    logic                    which_matrix;
    logic [POS_W-1:0]        packed_position;
    logic signed [VAL_W-1:0] element_value;
    logic                    start_compute;
  } load_beat_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0]    result_row;
    logic [OUT_IDX_W-1:0]    result_col;
    logic signed [VAL_W-1:0] result_value;
    logic                    last_of_run;
  } result_beat_t;

  // One result entry travelling down the chain of cells.
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
    logic [VAL_W-1:0] acc;
  } tok_t;

  // Broadcast write of one element into the cells of either matrix.
  typedef struct packed {
    logic             en_a;
    logic             en_b;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] data;
  } wr_t;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tri_pos_t;

  // Packed lower-triangle position to (row, col) with row >= col.
  function automatic tri_pos_t tri_decode(input logic [POS_W-1:0] pos);
    tri_pos_t tp;
    int       base;
    tp.row = '0;
    tp.col = '0;
    for (int t = 0; t < TRI_SCAN; t++) begin
      base = t * (t + 1) / 2;
      if (int'(pos) >= base) begin
        tp.row = IDX_W'(t);
        tp.col = IDX_W'(int'(pos) - base);
      end
    end
    return tp;
  endfunction

endpackage

// ===== design/psm_cell.sv =====
// One cell of the chain: keeps row CELL_IDX of both symmetric matrices and
// adds its term to the entry that passes through. Depends on psm_pkg.
module psm_cell #(
  parameter int DIM      = psm_pkg::DIM_DEF,
  parameter int CELL_IDX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            mode,
  input  logic            advance,
  input  psm_pkg::wr_t    wr,
  input  psm_pkg::tok_t   tok_in,
  output psm_pkg::tok_t   tok_out
);

  localparam int ROW_W = $clog2(DIM);

  logic [psm_pkg::VAL_W-1:0] a_row [DIM];
  logic [psm_pkg::VAL_W-1:0] b_row [DIM];
  logic [DIM-1:0]            hit;
  logic [psm_pkg::IDX_W-1:0] self_idx;
  logic [psm_pkg::VAL_W-1:0] a_rd;
  logic [psm_pkg::VAL_W-1:0] b_rd;
  logic [psm_pkg::VAL_W-1:0] prod;
  logic [psm_pkg::VAL_W-1:0] term;
  psm_pkg::tok_t             tok_next;

  assign self_idx = psm_pkg::IDX_W'(CELL_IDX);

  // Element (i,j) lands at entry j of cell i and at entry i of cell j.
  always_comb begin
    for (int e = 0; e < DIM; e++) begin
      hit[e] = (wr.row == self_idx && wr.col == psm_pkg::IDX_W'(e)) ||
               (wr.col == self_idx && wr.row == psm_pkg::IDX_W'(e));
    end
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < DIM; e++) begin
      if (wr.en_a && hit[e]) begin
        a_row[e] <= wr.data;
      end
      if (wr.en_b && hit[e]) begin
        b_row[e] <= wr.data;
      end
    end
  end

  // By symmetry A(r,k) is entry r of cell k; in add mode A(r,c) and B(r,c)
  // are entry r of cell c.
  assign a_rd = a_row[tok_in.row[ROW_W-1:0]];
  assign b_rd = (mode == psm_pkg::MODE_PRODUCT) ? b_row[tok_in.col[ROW_W-1:0]]
                                                : b_row[tok_in.row[ROW_W-1:0]];
  assign prod = a_rd * b_rd;

  always_comb begin
    if (mode == psm_pkg::MODE_PRODUCT) begin
      term = prod;
    end else if (tok_in.col == self_idx) begin
      term = a_rd + b_rd;
    end else begin
      term = '0;
    end
    tok_next     = tok_in;
    tok_next.acc = tok_in.acc + term;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      tok_out <= tok_next;
    end
  end

endmodule

// ===== design/psm_seq.sv =====
// Entry sequencer: after a start it feeds the DIM*DIM result entries into
// the head of the cell chain in row-major order. Depends on psm_pkg.
module psm_seq #(
  parameter int DIM = psm_pkg::DIM_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          advance,
  output psm_pkg::tok_t tok
);

  localparam int ROW_W = $clog2(DIM);

  logic             active;
  logic [ROW_W-1:0] row;
  logic [ROW_W-1:0] col;
  logic             row_end;
  logic             col_end;

  assign col_end = (col == ROW_W'(DIM - 1));
  assign row_end = (row == ROW_W'(DIM - 1));

  always_comb begin
    tok.valid = active;
    tok.row   = psm_pkg::IDX_W'(row);
    tok.col   = psm_pkg::IDX_W'(col);
    tok.last  = row_end && col_end;
    tok.acc   = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      row    <= '0;
      col    <= '0;
    end else if (start) begin
      active <= 1'b1;
      row    <= '0;
      col    <= '0;
    end else if (active && advance) begin
      if (col_end) begin
        col <= '0;
        if (row_end) begin
          active <= 1'b0;
        end else begin
          row <= row + 1'b1;
        end
      end else begin
        col <= col + 1'b1;
      end
    end
  end

endmodule

// ===== design/packed_symmetric_matrix_mac.sv =====
// Packed symmetric matrix multiply-accumulate, top level.
// A load beat is taken while no run is active; one with start_compute set
// opens a run, whose entries leave the sequencer, pass the DIM cells and the
// output register, one beat a cycle while unstalled; loads wait for the last.
// Reset (rst, synchronous) empties the chain and sets operation_mode to 1;
// matrix contents stay undefined until written.
module packed_symmetric_matrix_mac #(
  parameter int DIM = psm_pkg::DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  mode_write,
  input  logic                  mode_data,
  input  logic                  load_valid,
  output logic                  load_stall,
  input  psm_pkg::load_beat_t   load_beat,
  output logic                  result_valid,
  input  logic                  result_stall,
  output psm_pkg::result_beat_t result_beat
);

  localparam int PACKED_DEPTH = DIM * (DIM + 1) / 2;

  // Configuration: 0 gives the elementwise sum, 1 the matrix product.
  logic mode;

  // High from the start beat until the last result beat has been taken.
  // Loads are held off during that time so that the stores stay still.
  logic run_active;

  logic              load_take;
  logic              start;
  logic              pos_ok;
  logic              advance;
  psm_pkg::tri_pos_t tp;
  psm_pkg::wr_t      wr;
  psm_pkg::tok_t     chain [DIM+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= psm_pkg::MODE_PRODUCT;
    end else if (mode_write) begin
      mode <= mode_data;
    end
  end

  assign load_stall = run_active;
  assign load_take  = load_valid && !run_active;
  assign start      = load_take && load_beat.start_compute;

  // A position past the end of the packed store writes nothing, but a start
  // on such a beat still runs.
  assign tp     = psm_pkg::tri_decode(load_beat.packed_position);
  assign pos_ok = int'(load_beat.packed_position) < PACKED_DEPTH;

  always_comb begin
    wr.en_a = load_take && pos_ok && !load_beat.which_matrix;
    wr.en_b = load_take && pos_ok && load_beat.which_matrix;
    wr.row  = tp.row;
    wr.col  = tp.col;
    wr.data = load_beat.element_value;
  end

  // The whole chain moves together whenever the output register can take
  // the entry at its tail, so a stalled result freezes every cell.
  assign advance = !result_valid || !result_stall;

  psm_seq #(
    .DIM (DIM)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .advance (advance),
    .tok     (chain[0])
  );

  // Cell k holds row k of both matrices; an entry is complete after all DIM
  // cells. Product: one MAC per cell (term k); sum: A+B only in cell col.
  for (genvar k = 0; k < DIM; k++) begin : g_cell
    psm_cell #(
      .DIM      (DIM),
      .CELL_IDX (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .mode    (mode),
      .advance (advance),
      .wr      (wr),
      .tok_in  (chain[k]),
      .tok_out (chain[k+1])
    );
  end

  // Output register: separates the chain from the result channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= chain[DIM].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_beat.result_row   <= psm_pkg::OUT_IDX_W'(chain[DIM].row);
      result_beat.result_col   <= psm_pkg::OUT_IDX_W'(chain[DIM].col);
      result_beat.result_value <= chain[DIM].acc;
      result_beat.last_of_run  <= chain[DIM].last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_active <= 1'b0;
    end else if (start) begin
      run_active <= 1'b1;
    end else if (result_valid && !result_stall && result_beat.last_of_run) begin
      run_active <= 1'b0;
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the packed symmetric matrix multiply-accumulate block.
// Uses the beat types from psm_pkg and instantiates packed_symmetric_matrix_mac as dut.
// Stimulus is a directed table, then random phases. All checking is done in this file.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM          = psm_pkg::DIM_DEF;
  localparam int DEPTH        = DIM * (DIM + 1) / 2;
  // Quiet cycles that let any run still in the cell chain drain out.
  localparam int SETTLE       = 2 * (DIM * DIM + DIM + 2);
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 70;
  localparam int CYCLE_LIMIT  = 300000;

  // One row of the directed table. When typed is set, every entry of the
  // run that the row starts is expected to equal typed_value.
  typedef struct packed {
    logic                      which;
    logic [psm_pkg::POS_W-1:0] pos;
    logic [psm_pkg::VAL_W-1:0] value;
    logic                      start;
    logic                      typed;
    logic [psm_pkg::VAL_W-1:0] typed_value;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  mode_write;
  logic                  mode_data;
  logic                  load_valid;
  logic                  load_stall;
  psm_pkg::load_beat_t   load_beat;
  logic                  result_valid;
  logic                  result_stall;
  psm_pkg::result_beat_t result_beat;

  // Shadow copy of the block's state, updated when a beat is accepted.
  logic [psm_pkg::VAL_W-1:0] first_shadow  [DEPTH];
  logic [psm_pkg::VAL_W-1:0] second_shadow [DEPTH];
  logic                      mode_shadow = psm_pkg::MODE_PRODUCT;

  // Result entries still owed by the block, oldest first.
  psm_pkg::result_beat_t pending_entries [$];

  int  error_count  = 0;
  int  cycle_count  = 0;
  bit  quiet_tail   = 1'b0;
  bit  hold_off_req = 1'b0;

  stim_row_t directed_rows [25];

  packed_symmetric_matrix_mac #(.DIM(DIM)) dut (
    .clk          (clk),
    .rst          (rst),
    .mode_write   (mode_write),
    .mode_data    (mode_data),
    .load_valid   (load_valid),
    .load_stall   (load_stall),
    .load_beat    (load_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Reads element (r,c) of a symmetric matrix from its packed lower triangle.
  function automatic logic [psm_pkg::VAL_W-1:0] sym_element(bit second, int r, int c);
    int hi;
    int lo;
    hi = (r >= c) ? r : c;
    lo = (r >= c) ? c : r;
    return second ? second_shadow[hi * (hi + 1) / 2 + lo] : first_shadow[hi * (hi + 1) / 2 + lo];
  endfunction

  // Stores one accepted load beat in the shadow matrices and, when the beat
  // opens a run, queues the full row-major result. Products and sums wrap
  // at 32 bits simply by working in 32-bit vectors.
  function automatic void predict_matrix_run(psm_pkg::load_beat_t b, bit typed,
                                             logic [psm_pkg::VAL_W-1:0] typed_value);
    psm_pkg::result_beat_t     entry;
    logic [psm_pkg::VAL_W-1:0] acc;
    if (int'(b.packed_position) < DEPTH) begin
      if (b.which_matrix)
        second_shadow[b.packed_position] = b.element_value;
      else
        first_shadow[b.packed_position] = b.element_value;
    end
    if (!b.start_compute)
      return;
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        if (mode_shadow == psm_pkg::MODE_PRODUCT) begin
          acc = '0;
          for (int k = 0; k < DIM; k++)
            acc = acc + sym_element(1'b0, r, k) * sym_element(1'b1, k, c);
        end else begin
          acc = sym_element(1'b0, r, c) + sym_element(1'b1, r, c);
        end
        entry.result_row   = psm_pkg::OUT_IDX_W'(r);
        entry.result_col   = psm_pkg::OUT_IDX_W'(c);
        entry.result_value = typed ? typed_value : acc;
        entry.last_of_run  = (r == DIM - 1) && (c == DIM - 1);
        pending_entries.push_back(entry);
      end
    end
  endfunction

  // Offers one load beat, holding it until the block takes it. A random gap
  // may come first, except in the quiet tail and while the result side is
  // being held off, when the sender keeps pushing so the block backs up.
  task automatic offer_beat(psm_pkg::load_beat_t b, bit typed,
                            logic [psm_pkg::VAL_W-1:0] typed_value);
    if (!quiet_tail && !hold_off_req && $urandom_range(0, 3) == 0) begin
      load_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    load_valid <= 1'b1;
    load_beat  <= b;
    @(posedge clk);
    while (load_stall) @(posedge clk);
    predict_matrix_run(b, typed, typed_value);
  endtask

  // Waits for every owed result, then lets the chain settle so that the
  // block is idle before the mode register is touched again.
  task automatic drain_and_settle();
    load_valid <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes operation_mode; the caller guarantees the block is idle.
  task automatic set_mode(logic m);
    mode_write <= 1'b1;
    mode_data  <= m;
    @(posedge clk);
    mode_write  <= 1'b0;
    mode_shadow = m;
  endtask

  // Result side back-pressure. Bursts of stall and of no stall alternate at
  // random, a single long hold-off can be requested by the stimulus, and in
  // the quiet tail the receiver never stalls.
  initial begin
    result_stall <= 1'b0;
    forever begin
      if (hold_off_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        result_stall <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
  end

  // Result checker. Every accepted result beat is matched against the
  // oldest owed entry, field by field.
  always @(posedge clk) begin
    psm_pkg::result_beat_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_entries.size() == 0) begin
        $error("result beat with nothing owed: row %0d col %0d value %0d",
               result_beat.result_row, result_beat.result_col,
               $signed(result_beat.result_value));
        error_count++;
      end else begin
        want = pending_entries.pop_front();
        if (result_beat.result_row !== want.result_row) begin
          $error("result_row mismatch: expected %0d, actual %0d",
                 want.result_row, result_beat.result_row);
          error_count++;
        end
        if (result_beat.result_col !== want.result_col) begin
          $error("result_col mismatch: expected %0d, actual %0d",
                 want.result_col, result_beat.result_col);
          error_count++;
        end
        if (result_beat.result_value !== want.result_value) begin
          $error("result_value mismatch: expected %0d, actual %0d",
                 $signed(want.result_value), $signed(result_beat.result_value));
          error_count++;
        end
        if (result_beat.last_of_run !== want.last_of_run) begin
          $error("last_of_run mismatch: expected %0d, actual %0d",
                 want.last_of_run, result_beat.last_of_run);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    psm_pkg::load_beat_t nb;
    int                  useful;
    int                  pick;

    rst        <= 1'b1;
    mode_write <= 1'b0;
    mode_data  <= 1'b0;
    load_valid <= 1'b0;
    load_beat  <= '0;

    // Directed table. The first matrix is cleared, the second gets the
    // value extremes, and the multiply runs that follow are all zero at a
    // glance. An out-of-range position must write nothing, even when it
    // also starts a run. The last rows give the first matrix the extremes
    // and are left to the predictor.
    directed_rows = '{
      '{1'b0, 4'd0,  32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, 4'd1,  32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, 4'd2,  32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, 4'd3,  32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, 4'd4,  32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, 4'd5,  32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, 4'd6,  32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, 4'd7,  32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, 4'd8,  32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b0, 4'd9,  32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b1, 4'd0,  32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{1'b1, 4'd1,  32'h8000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b1, 4'd2,  32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
      '{1'b1, 4'd3,  32'h0000_0001, 1'b0, 1'b0, 32'h0},
      '{1'b1, 4'd4,  32'h0000_0000, 1'b0, 1'b0, 32'h0},
      '{1'b1, 4'd5,  32'h5555_5555, 1'b0, 1'b0, 32'h0},
      '{1'b1, 4'd6,  32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},
      '{1'b1, 4'd7,  32'h8000_0001, 1'b0, 1'b0, 32'h0},
      '{1'b1, 4'd8,  32'h7FFF_FFFE, 1'b0, 1'b0, 32'h0},
      '{1'b1, 4'd9,  32'h1234_5678, 1'b1, 1'b1, 32'h0},
      '{1'b0, 4'd15, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0},
      '{1'b1, 4'd10, 32'h0000_0005, 1'b1, 1'b1, 32'h0},
      '{1'b0, 4'd0,  32'h0000_0001, 1'b0, 1'b0, 32'h0},
      '{1'b0, 4'd9,  32'h8000_0000, 1'b1, 1'b0, 32'h0},
      '{1'b0, 4'd5,  32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Write the reset value explicitly so the register is covered from the
    // first phase onward.
    set_mode(psm_pkg::MODE_PRODUCT);

    foreach (directed_rows[i]) begin
      nb.which_matrix    = directed_rows[i].which;
      nb.packed_position = directed_rows[i].pos;
      nb.element_value   = directed_rows[i].value;
      nb.start_compute   = directed_rows[i].start;
      offer_beat(nb, directed_rows[i].typed, directed_rows[i].typed_value);
    end
    drain_and_settle();

    // Random phases. Every element is written by now, so any beat may start a
    // run. Mode alternates over the first four phases, then is random; the third
    // carries the long receiver hold-off and the last runs with no idling at all.
    for (int phase = 0; phase < PHASES; phase++) begin
      set_mode((phase < 4) ? phase[0] : logic'($urandom_range(0, 1)));
      if (phase == 2)
        hold_off_req = 1'b1;
      if (phase == PHASES - 1)
        quiet_tail = 1'b1;
      useful = 0;
      while (useful < PHASE_ITEMS) begin
        nb.which_matrix    = 1'($urandom_range(0, 1));
        nb.packed_position = ($urandom_range(0, 6) == 0)
                             ? psm_pkg::POS_W'($urandom_range(10, 15))
                             : psm_pkg::POS_W'($urandom_range(0, 9));
        pick = $urandom_range(0, 7);
        case (pick)
          0:       nb.element_value = 32'h7FFF_FFFF;
          1:       nb.element_value = 32'h8000_0000;
          2:       nb.element_value = 32'h0000_0000;
          3:       nb.element_value = 32'hFFFF_FFFF;
          4:       nb.element_value = $signed($urandom_range(0, 32)) - 16;
          default: nb.element_value = $urandom;
        endcase
        nb.start_compute = ($urandom_range(0, 5) == 0);
        // Out-of-range loads that start nothing leave the block unchanged
        // and are not counted toward the phase.
        if (int'(nb.packed_position) < DEPTH || nb.start_compute)
          useful++;
        offer_beat(nb, 1'b0, '0);
      end
      drain_and_settle();
    end

    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
